### hdl/bitmap_slot_allocator_mark_sweep_core_macros.svh
// ----------------------------------------------------------------------------
// Bitmap slot allocator assertion macros
// Shared concurrent assertion forms used by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SLOT_ALLOCATOR_MARK_SWEEP_CORE_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_MARK_SWEEP_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BSA_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bsa assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define BSA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bsa assertion failed");

`endif

### hdl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator package
// Sizes, request and result codes, payload types and shared helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

    localparam int BITMAP_WORDS = 64;
    localparam int WORD_BITS    = 64;
    localparam int WIDX         = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_MARK  = 2'd1;
    localparam logic [1:0] REQ_SWEEP = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] RES_ALLOC = 2'd0;
    localparam logic [1:0] RES_OOM   = 2'd1;
    localparam logic [1:0] RES_MARK  = 2'd2;
    localparam logic [1:0] RES_SWEEP = 2'd3;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] slot_index;
    } bsa_req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [11:0] slot_out;
        logic [5:0]  word_index;
        logic [63:0] freed_mask;
        logic        last;
    } bsa_rsp_t;

    typedef struct packed {
        logic       shift;
        logic       mark;
        logic [5:0] mark_word;
        logic [5:0] mark_bit;
    } bsa_cell_ctl_t;

    function automatic logic [5:0] lowest_clear(input logic [63:0] w);
        logic [5:0] pos;
        pos = 6'd0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w[b]) begin
                pos = 6'(b);
            end
        end
        return pos;
    endfunction

endpackage

`default_nettype wire

### hdl/bsa_cell.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator cell
// Holds one occupancy word and one mark word and hands both to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bsa_pkg::bsa_cell_ctl_t ctl,
    input  wire logic                  hit,
    input  wire logic [63:0]           occ_in,
    input  wire logic [63:0]           mrk_in,
    output logic [63:0]                occ,
    output logic [63:0]                mrk
);
    import bsa_pkg::*;

    logic [63:0] occ_reg;
    logic [63:0] occ_next;
    logic [63:0] mrk_reg;
    logic [63:0] mrk_next;

    always_comb
    begin
        occ_next = occ_reg;
        mrk_next = mrk_reg;
        if (ctl.shift)
        begin
            occ_next = occ_in;
            mrk_next = mrk_in;
        end
        else if (hit)
        begin
            mrk_next = mrk_reg | (64'd1 << ctl.mark_bit);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
            mrk_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            mrk_reg <= mrk_next;
        end
    end

    assign occ = occ_reg;
    assign mrk = mrk_reg;

endmodule

`default_nettype wire

### hdl/bsa_ctrl.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator control
// Sequences the ring rotation, edits the word at the head and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_stall,
    input  wire bsa_pkg::bsa_req_t      req,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output bsa_pkg::bsa_rsp_t           rsp,
    input  wire logic [63:0]            head_occ,
    input  wire logic [63:0]            head_mrk,
    output logic [63:0]                 tail_occ,
    output logic [63:0]                 tail_mrk,
    output bsa_pkg::bsa_cell_ctl_t      cell_ctl
);
    import bsa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_ALLOC_OUT,
        ST_SWEEP
    } state_t;

    state_t          state_reg;
    logic [WIDX-1:0] cnt_reg;
    logic            found_reg;
    logic [11:0]     slot_reg;
    logic            rsp_valid_reg;
    bsa_rsp_t        rsp_reg;

    logic            out_free;
    logic            accept;
    logic            full;
    logic [5:0]      clr_bit;
    logic            last_word;
    logic [WIDX-1:0] cnt_next;
    logic            in_pool;
    logic [63:0]     freed;
    logic            rsp_load;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept    = req_valid && !req_stall;
    assign full      = &head_occ;
    assign clr_bit   = lowest_clear(head_occ);
    assign last_word = (cnt_reg == WIDX'(BITMAP_WORDS - 1));
    assign cnt_next  = last_word ? '0 : cnt_reg + 1'b1;
    assign in_pool   = ({1'b0, req.slot_index[11:6]} < 7'(BITMAP_WORDS));
    assign freed     = head_occ & ~head_mrk;
    assign rsp_load  = out_free
                       && ((accept && (req.req_type == REQ_MARK))
                           || (state_reg == ST_ALLOC_OUT)
                           || (state_reg == ST_SWEEP));

    always_comb
    begin
        cell_ctl.shift     = 1'b0;
        cell_ctl.mark      = accept && (req.req_type == REQ_MARK) && in_pool;
        cell_ctl.mark_word = req.slot_index[11:6];
        cell_ctl.mark_bit  = req.slot_index[5:0];
        tail_occ           = head_occ;
        tail_mrk           = head_mrk;
        case (state_reg)
            ST_ALLOC:
            begin
                cell_ctl.shift = 1'b1;
                if (!found_reg && !full)
                begin
                    tail_occ = head_occ | (64'd1 << clr_bit);
                end
            end
            ST_SWEEP:
            begin
                cell_ctl.shift = out_free;
                tail_occ       = head_occ & head_mrk;
                tail_mrk       = '0;
            end
            default:
            begin
                cell_ctl.shift = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            slot_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (req.req_type)
                            REQ_ALLOC:
                            begin
                                state_reg <= ST_ALLOC;
                                cnt_reg   <= '0;
                                found_reg <= 1'b0;
                            end
                            REQ_MARK:
                            begin
                                rsp_reg <= '{RES_MARK, 12'd0, 6'd0, 64'd0, 1'b1};
                            end
                            REQ_SWEEP:
                            begin
                                state_reg <= ST_SWEEP;
                                cnt_reg   <= '0;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_ALLOC:
                begin
                    cnt_reg <= cnt_next;
                    if (!found_reg && !full)
                    begin
                        found_reg <= 1'b1;
                        slot_reg  <= {6'(cnt_reg), clr_bit};
                    end
                    if (last_word)
                    begin
                        state_reg <= ST_ALLOC_OUT;
                    end
                end
                ST_ALLOC_OUT:
                begin
                    if (out_free)
                    begin
                        if (found_reg)
                        begin
                            rsp_reg <= '{RES_ALLOC, slot_reg, 6'd0, 64'd0, 1'b1};
                        end
                        else
                        begin
                            rsp_reg <= '{RES_OOM, 12'd0, 6'd0, 64'd0, 1'b1};
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                ST_SWEEP:
                begin
                    if (out_free)
                    begin
                        rsp_reg <= '{RES_SWEEP, 12'd0, 6'(cnt_reg), freed, last_word};
                        cnt_reg <= cnt_next;
                        if (last_word)
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

### hdl/bitmap_slot_allocator_mark_sweep_core.sv
// Mark: result registered the cycle after accept; next may follow unless stalled.
// Allocate: one full rotation of the cell ring, then the result is registered.
// Sweep: BITMAP_WORDS results, one per cycle while the result side is not stalled.
// Reset: asynchronous, active low; every occupancy and mark bit clears at once.
// ----------------------------------------------------------------------------
// Bitmap slot allocator with mark and sweep
// A ring of word cells rotates past a control head that allocates and sweeps.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator_mark_sweep_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire bsa_pkg::bsa_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output bsa_pkg::bsa_rsp_t      rsp
);
    import bsa_pkg::*;

    logic [63:0]   occ_w [BITMAP_WORDS];
    logic [63:0]   mrk_w [BITMAP_WORDS];
    logic [63:0]   tail_occ;
    logic [63:0]   tail_mrk;
    bsa_cell_ctl_t cell_ctl;

    bsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .head_occ  (occ_w[0]),
        .head_mrk  (mrk_w[0]),
        .tail_occ  (tail_occ),
        .tail_mrk  (tail_mrk),
        .cell_ctl  (cell_ctl)
    );

    for (genvar k = 0; k < BITMAP_WORDS; k++)
    begin : g_cell
        logic [63:0] occ_in;
        logic [63:0] mrk_in;
        logic        hit;

        if (k == BITMAP_WORDS - 1)
        begin : g_tail
            assign occ_in = tail_occ;
            assign mrk_in = tail_mrk;
        end
        else
        begin : g_link
            assign occ_in = occ_w[k + 1];
            assign mrk_in = mrk_w[k + 1];
        end

        assign hit = cell_ctl.mark && (cell_ctl.mark_word == 6'(k));

        bsa_cell u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (cell_ctl),
            .hit    (hit),
            .occ_in (occ_in),
            .mrk_in (mrk_in),
            .occ    (occ_w[k]),
            .mrk    (mrk_w[k])
        );
    end

endmodule

`default_nettype wire

### hdl/bsa_checker.sv
// ----------------------------------------------------------------------------
// Bitmap slot allocator checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bitmap_slot_allocator_mark_sweep_core_macros.svh"

module bsa_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_stall,
    input  wire logic              rsp_valid,
    input  wire logic              rsp_stall,
    input  wire bsa_pkg::bsa_rsp_t rsp
);
    import bsa_pkg::*;

    `BSA_ASSERT_NOW(a_single_last, rsp_valid && (rsp.result_kind != RES_SWEEP), rsp.last)
    `BSA_ASSERT_NOW(a_slot_only_alloc, rsp_valid && (rsp.result_kind != RES_ALLOC),
                    rsp.slot_out == 12'd0)
    `BSA_ASSERT_NOW(a_mask_only_sweep, rsp_valid && (rsp.result_kind != RES_SWEEP),
                    (rsp.freed_mask == 64'd0) && (rsp.word_index == 6'd0))
    `BSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
    `BSA_ASSERT_NOW(a_busy_stall, rsp_valid && rsp_stall, req_stall)

endmodule

bind bitmap_slot_allocator_mark_sweep_core bsa_checker u_bsa_checker (.*);

`default_nettype wire

### dv/tb_bitmap_slot_allocator_mark_sweep_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bitmap slot allocator mark and sweep testbench
// Drives allocate, mark, sweep and unused requests through the valid and stall
// handshake with random idling on both sides. A local model of the occupancy
// and mark bitmaps predicts every result, and each accepted result is checked
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bitmap_slot_allocator_mark_sweep_core;

    import bsa_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 150;
    localparam int RANDOM_ITEMS   = 370;
    localparam int POOL_SLOTS     = BITMAP_WORDS * WORD_BITS;
    localparam int PRINT_LIMIT    = 60;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_stall;
    bsa_req_t req       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    bsa_rsp_t rsp;

    logic [WORD_BITS-1:0] occupancy  [BITMAP_WORDS];
    logic [WORD_BITS-1:0] live_marks [BITMAP_WORDS];
    bsa_rsp_t             expected_rsp [$];
    logic [11:0]          live_slots [$];
    bsa_rsp_t             want_rsp;
    bit                   calm = 1'b0;
    int                   mismatch_count = 0;
    int                   idle_cycles = 0;

    bitmap_slot_allocator_mark_sweep_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        rsp_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 9);
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
        end
        mismatch_count++;
    endtask

    task automatic predict_request(input bsa_req_t r);
        bsa_rsp_t e;
        int       w;
        int       b;
        int       i;
        bit       found;
        e = '0;
        e.last = 1'b1;
        case (r.req_type)
            REQ_ALLOC:
            begin
                e.result_kind = RES_OOM;
                found = 1'b0;
                for (w = 0; w < BITMAP_WORDS; w++)
                begin
                    for (b = 0; b < WORD_BITS; b++)
                    begin
                        if (!found && !occupancy[w][b])
                        begin
                            found = 1'b1;
                            occupancy[w][b] = 1'b1;
                            e.result_kind = RES_ALLOC;
                            e.slot_out = 12'(w * WORD_BITS + b);
                            live_slots.push_back(e.slot_out);
                        end
                    end
                end
                expected_rsp.push_back(e);
            end
            REQ_MARK:
            begin
                w = int'(r.slot_index[11:6]);
                if (w < BITMAP_WORDS)
                begin
                    live_marks[w][r.slot_index[5:0]] = 1'b1;
                end
                e.result_kind = RES_MARK;
                expected_rsp.push_back(e);
            end
            REQ_SWEEP:
            begin
                for (w = 0; w < BITMAP_WORDS; w++)
                begin
                    e.result_kind = RES_SWEEP;
                    e.word_index = 6'(w);
                    e.freed_mask = occupancy[w] & ~live_marks[w];
                    e.last = (w == BITMAP_WORDS - 1);
                    occupancy[w] = occupancy[w] & live_marks[w];
                    live_marks[w] = '0;
                    expected_rsp.push_back(e);
                end
                for (i = live_slots.size() - 1; i >= 0; i--)
                begin
                    if (!occupancy[live_slots[i][11:6]][live_slots[i][5:0]])
                    begin
                        live_slots.delete(i);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_request(input logic [1:0] kind, input logic [11:0] slot);
        bsa_req_t r;
        int       gap;
        r.req_type = kind;
        r.slot_index = slot;
        if (!calm && $urandom_range(0, 99) < 9)
        begin
            req_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        predict_request(r);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("result with nothing expected", 64'(rsp), '0);
            end
            else
            begin
                want_rsp = expected_rsp.pop_front();
                if (rsp.result_kind != want_rsp.result_kind)
                    report_mismatch("result_kind", 64'(rsp.result_kind),
                                    64'(want_rsp.result_kind));
                if (rsp.slot_out != want_rsp.slot_out)
                    report_mismatch("slot_out", 64'(rsp.slot_out), 64'(want_rsp.slot_out));
                if (rsp.word_index != want_rsp.word_index)
                    report_mismatch("word_index", 64'(rsp.word_index),
                                    64'(want_rsp.word_index));
                if (rsp.freed_mask != want_rsp.freed_mask)
                    report_mismatch("freed_mask", rsp.freed_mask, want_rsp.freed_mask);
                if (rsp.last != want_rsp.last)
                    report_mismatch("last", 64'(rsp.last), 64'(want_rsp.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic test_alloc_after_reset();
        send_request(REQ_ALLOC, 12'h000);
        send_request(REQ_ALLOC, 12'hFFF);
        send_request(REQ_ALLOC, 12'h000);
        send_request(REQ_NONE, 12'hFFF);
        send_request(REQ_NONE, 12'h000);
    endtask

    task automatic test_mark_and_sweep_cases();
        send_request(REQ_MARK, 12'd0);
        send_request(REQ_MARK, 12'd0);
        send_request(REQ_MARK, 12'd4095);
        send_request(REQ_MARK, 12'd2);
        send_request(REQ_SWEEP, 12'hFFF);
        send_request(REQ_ALLOC, 12'h555);
        send_request(REQ_MARK, 12'hAAA);
        send_request(REQ_MARK, 12'h555);
        send_request(REQ_SWEEP, 12'h000);
        send_request(REQ_ALLOC, 12'hAAA);
        send_request(REQ_SWEEP, 12'h000);
    endtask

    task automatic test_pool_exhaustion();
        int n;
        calm = 1'b1;
        for (n = 0; n < POOL_SLOTS + 2; n++)
        begin
            if (n == 1024)
            begin
                calm = 1'b0;
            end
            send_request(REQ_ALLOC, 12'($urandom()));
        end
        send_request(REQ_MARK, 12'd4095);
        send_request(REQ_MARK, 12'd0);
        repeat (40) send_request(REQ_MARK, 12'($urandom()));
        send_request(REQ_SWEEP, 12'($urandom()));
        repeat (5) send_request(REQ_ALLOC, 12'($urandom()));
    endtask

    task automatic test_random_traffic();
        int n;
        int pick;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                send_request(REQ_ALLOC, 12'($urandom()));
            end
            else if (pick < 75 && live_slots.size() != 0)
            begin
                send_request(REQ_MARK,
                             live_slots[$urandom_range(0, live_slots.size() - 1)]);
            end
            else if (pick < 80)
            begin
                send_request(REQ_NONE, 12'($urandom()));
            end
            else if (pick < 85)
            begin
                send_request(REQ_SWEEP, 12'($urandom()));
            end
            else
            begin
                send_request(REQ_MARK, 12'($urandom()));
            end
        end
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        for (int w = 0; w < BITMAP_WORDS; w++)
        begin
            occupancy[w] = '0;
            live_marks[w] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_alloc_after_reset();
        test_mark_and_sweep_cases();
        test_pool_exhaustion();
        test_random_traffic();
        drain_results();
        if (expected_rsp.size() != 0)
        begin
            report_mismatch("results never arrived", 64'(expected_rsp.size()), '0);
        end
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
